[rtl/core/gbd_pkg.sv]
// Shared constants, types and codes of the GPIO button debouncer.
`default_nettype none

package gbd_pkg;

	localparam int GBD_PIN_COUNT = 32;
	localparam int GBD_PIN_W     = 32;
	localparam int GBD_TIME_W    = 32;
	localparam int GBD_DELAY_W   = 16;
	localparam int GBD_CFG_W     = 32;
	localparam int GBD_ADDR_W    = 1;

	localparam logic [GBD_ADDR_W-1:0] CFG_DEBOUNCE_DELAY = 1'b0;
	localparam logic [GBD_ADDR_W-1:0] CFG_BUTTON_MASK    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [GBD_DELAY_W-1:0] delay_ms;
		logic [GBD_PIN_W-1:0]   button_mask;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/core/gbd_elapsed.sv]
// Shared elapsed-time unit: wrapping subtract of a pin's stamp and compare against the delay.
`default_nettype none

module gbd_elapsed
	import gbd_pkg::*;
(
	input  wire logic [GBD_TIME_W-1:0]  now_ms,
	input  wire logic [GBD_TIME_W-1:0]  stamp_ms,
	input  wire logic [GBD_DELAY_W-1:0] delay_ms,
	output logic                        expired
);

	logic [GBD_TIME_W-1:0] elapsed;

	// The subtraction wraps modulo 2^32, so a jump back in time reads as a long gap.
	assign elapsed = now_ms - stamp_ms;
	assign expired = elapsed >= {{(GBD_TIME_W-GBD_DELAY_W){1'b0}}, delay_ms};

endmodule

`default_nettype wire

[rtl/core/gbd_seq.sv]
// Pin walking sequencer with the per-pin toggle time store and the result register.
`default_nettype none

module gbd_seq
	import gbd_pkg::*;
#(
	parameter int PIN_COUNT = GBD_PIN_COUNT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [GBD_PIN_W-1:0]  pin_levels,
	input  wire logic [GBD_TIME_W-1:0] now_ms,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [GBD_PIN_W-1:0]       debounced_pins
);

	localparam int PIN_LIMIT = (PIN_COUNT < GBD_PIN_W) ? PIN_COUNT : GBD_PIN_W;
	localparam int IDX_W     = (PIN_LIMIT > 1) ? $clog2(PIN_LIMIT) : 1;
	localparam int CNT_W     = $clog2(PIN_LIMIT + 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(PIN_LIMIT);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PIN_LIMIT - 1);
	localparam logic [GBD_PIN_W-1:0] RANGE_MASK = (PIN_LIMIT >= GBD_PIN_W) ?
		{GBD_PIN_W{1'b1}} : GBD_PIN_W'((64'd1 << PIN_LIMIT) - 64'd1);

	state_t state_q, state_d;

	logic [GBD_PIN_W-1:0]  deb_q;
	logic [GBD_PIN_W-1:0]  change_q;
	logic [GBD_TIME_W-1:0] now_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  out_valid_q;
	logic [GBD_PIN_W-1:0]  out_data_q;

	logic                  cmp_v_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic [GBD_TIME_W-1:0] rd_data_s1;
	logic                  rd_ok_s1;

	logic [GBD_TIME_W-1:0] mem [PIN_LIMIT];
	logic [PIN_LIMIT-1:0]  mem_ok_q;

	logic [GBD_PIN_W-1:0]  buttons;
	logic [GBD_PIN_W-1:0]  pressed;
	logic [GBD_PIN_W-1:0]  change;
	logic                  accept;
	logic                  direct;
	logic                  issue;
	logic [IDX_W-1:0]      rd_addr;
	logic [GBD_TIME_W-1:0] stamp;
	logic                  expired;
	logic                  toggle;
	logic                  walk_end;
	logic                  load_out;

	assign buttons = cfg.button_mask & RANGE_MASK;
	assign pressed = ~pin_levels & buttons;
	assign change  = (pressed ^ deb_q) & buttons;
	assign accept  = in_valid && in_ready;
	// With no delay, or no button pin differing, the pressed set is taken as it stands.
	assign direct  = (cfg.delay_ms == '0) || (change == '0);
	assign rd_addr = rd_cnt_q[IDX_W-1:0];

	// A pin that was never toggled reads as stamped at time zero.
	assign stamp    = rd_ok_s1 ? rd_data_s1 : '0;
	assign toggle   = cmp_v_s1 && change_q[cmp_idx_s1] && expired;
	assign walk_end = cmp_v_s1 && (cmp_idx_s1 == IDX_LAST);

	gbd_elapsed u_elapsed (
		.now_ms   (now_q),
		.stamp_ms (stamp),
		.delay_ms (cfg.delay_ms),
		.expired  (expired)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = direct ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		issue    = (state_q == ST_WALK) && (rd_cnt_q != CNT_END);
		load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			deb_q       <= '0;
			rd_cnt_q    <= '0;
			cmp_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= issue;
			if (accept) begin
				rd_cnt_q <= '0;
				if (direct) begin
					deb_q <= pressed;
				end
			end else if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNT_W'(1);
			end
			if (toggle) begin
				deb_q[cmp_idx_s1] <= ~deb_q[cmp_idx_s1];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			change_q <= change;
			now_q    <= now_ms;
		end
		if (issue) begin
			cmp_idx_s1 <= rd_addr;
		end
		if (load_out) begin
			out_data_q <= deb_q;
		end
	end

	// Time store: written on a toggle, read one pin ahead of the compare.
	always_ff @(posedge clk) begin
		if (toggle) begin
			mem[cmp_idx_s1] <= now_q;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_ok_q <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (toggle) begin
				mem_ok_q[cmp_idx_s1] <= 1'b1;
			end
			rd_ok_s1 <= mem_ok_q[rd_addr];
		end
	end

	assign out_valid      = out_valid_q;
	assign debounced_pins = out_data_q;

	a_busy_while_walking: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> !in_ready)
		else $error("input taken while a pin compare is in flight");

	a_toggle_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		toggle |-> (state_q == ST_WALK))
		else $error("time store written outside the pin walk");

	a_done_presents_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_ready) |=> (out_valid && state_q == ST_IDLE))
		else $error("finished poll not presented");

	a_walk_reaches_end: assert property (@(posedge clk) disable iff (!arst_n)
		walk_end |-> (rd_cnt_q == CNT_END))
		else $error("pin walk ended before every pin was read");

endmodule

`default_nettype wire

[rtl/core/gpio_button_debouncer_top.sv]
// Top level of the GPIO button debouncer: configuration registers and the pin walker.
`default_nettype none

// Each request is one poll of the active-low pin levels with a millisecond
// timestamp; each poll returns one debounced pressed mask. A poll that needs
// no per-pin check (zero delay, or no button pin differing) goes straight to
// the done state with the pressed set as its result. Otherwise the sequencer
// walks every pin below min(PIN_COUNT, 32) through one shared
// wrapping-subtract and compare unit, pin by pin, behind a registered
// read of the toggle time store. The result sits in an output register, so
// a new poll is accepted while the last result waits. The time store has a
// valid bit per pin, so reset needs no clearing pass. Configuration is to be
// written through cfg_we, cfg_addr and cfg_wdata only while the block is
// idle; the user must keep to this, as the block itself does not enforce it.
module gpio_button_debouncer_top
	import gbd_pkg::*;
#(
	parameter int PIN_COUNT = GBD_PIN_COUNT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [GBD_ADDR_W-1:0] cfg_addr,
	input  wire logic [GBD_CFG_W-1:0]  cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [GBD_PIN_W-1:0]  pin_levels,
	input  wire logic [GBD_TIME_W-1:0] now_ms,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [GBD_PIN_W-1:0]       debounced_pins
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_DEBOUNCE_DELAY: cfg_q.delay_ms    <= cfg_wdata[GBD_DELAY_W-1:0];
				CFG_BUTTON_MASK:    cfg_q.button_mask <= cfg_wdata[GBD_PIN_W-1:0];
				default: ;
			endcase
		end
	end

	gbd_seq #(
		.PIN_COUNT (PIN_COUNT)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pin_levels     (pin_levels),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.debounced_pins (debounced_pins)
	);

endmodule

`default_nettype wire
